// File: rtl/bta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bakery ticket arbiter package
// Operation and status codes and the records passed between the arbiter's
// ticket table and its grant selection.
// ----------------------------------------------------------------------------
package bta_pkg;

   typedef enum logic {
      OP_ACQUIRE = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_DUPLICATE = 2'd1,
      STATUS_NO_TICKET = 2'd2,
      STATUS_OVERFLOW  = 2'd3
   } status_type;

   localparam int ISSUED_BITS       = 16;
   localparam int GRANT_CLIENT_BITS = 4;
   localparam int REQ_CLIENT_BITS   = 4;

   typedef struct packed {
      status_type             status;
      logic [ISSUED_BITS-1:0] issued;
   } update_type;

   typedef struct packed {
      logic                         valid;
      logic [GRANT_CLIENT_BITS-1:0] client;
   } grant_type;

endpackage

// File: rtl/bakery_ticket_arbiter.sv
`timescale 1ns / 1ps
// A request beat accepted into the request register moves on to the update register and then to
// the response register, where it is offered as a response beat for the receiver to take.
// Throughput: one request and one response beat per cycle when the response is not stalled.
// The ticket table update sits between the request register and the grant stage.
// Reset clears every ticket and empties the pipeline; requests are taken from the next cycle.
// ----------------------------------------------------------------------------
// Bakery ticket arbiter
// Ticket-ordered lock arbiter: acquire issues the next ticket, release clears
// it, and every beat reports the client with the smallest held ticket.
// ----------------------------------------------------------------------------
module bakery_ticket_arbiter #(
   parameter int NUM_CLIENTS = 16,
   parameter int TICKET_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [3:0]  req_client,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_issued_ticket,
   output logic        rsp_grant_valid,
   output logic [3:0]  rsp_grant_client
);
   import bta_pkg::*;

   logic                       s1_valid_ff;
   op_type                     s1_op_ff;
   logic [REQ_CLIENT_BITS-1:0] s1_client_ff;
   logic                       s2_valid_ff;
   update_type                 s2_update_ff;
   update_type                 update_in;
   logic                       rsp_valid_ff;
   update_type                 rsp_update_ff;
   grant_type                  rsp_grant_ff;
   grant_type                  grant_in;
   logic [TICKET_BITS-1:0]     tickets [NUM_CLIENTS];
   logic                       adv1;
   logic                       adv2;
   logic                       adv3;

   assign adv3      = !rsp_valid_ff || !rsp_stall;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_stall = !adv1;

   bta_ticket_table #(
      .NUM_CLIENTS (NUM_CLIENTS),
      .TICKET_BITS (TICKET_BITS)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .apply      (s1_valid_ff && adv2),
      .op         (s1_op_ff),
      .client     (s1_client_ff),
      .update     (update_in),
      .tickets_ff (tickets)
   );

   bta_grant_select #(
      .NUM_CLIENTS (NUM_CLIENTS),
      .TICKET_BITS (TICKET_BITS)
   ) u_grant (
      .tickets (tickets),
      .grant   (grant_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_op_ff     <= op_type'(req_operation);
         s1_client_ff <= req_client;
      end
      if (adv2) begin
         s2_update_ff <= update_in;
      end
      if (adv3) begin
         rsp_update_ff <= s2_update_ff;
         rsp_grant_ff  <= grant_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_update_ff.status;
   assign rsp_issued_ticket = rsp_update_ff.issued;
   assign rsp_grant_valid   = rsp_grant_ff.valid;
   assign rsp_grant_client  = rsp_grant_ff.client;

endmodule

// File: rtl/bta_ticket_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bakery ticket table
// Holds one ticket per client, finds the largest held ticket with a
// comparator tree and applies one acquire or release per cycle while apply is high.
// ----------------------------------------------------------------------------
module bta_ticket_table #(
   parameter int NUM_CLIENTS = 16,
   parameter int TICKET_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 apply,
   input  bta_pkg::op_type                      op,
   input  logic [bta_pkg::REQ_CLIENT_BITS-1:0]  client,
   output bta_pkg::update_type                  update,
   output logic [TICKET_BITS-1:0]               tickets_ff [NUM_CLIENTS]
);
   import bta_pkg::*;

   localparam int CLIENT_BITS = $clog2(NUM_CLIENTS);
   localparam int NODES       = 1 << CLIENT_BITS;

   logic [TICKET_BITS-1:0] max_node [2*NODES-1];
   logic [TICKET_BITS-1:0] largest;
   logic [TICKET_BITS-1:0] wr_value;
   logic [NUM_CLIENTS-1:0] held;
   logic [CLIENT_BITS-1:0] idx;
   logic                   client_ok;
   logic                   wr_en;

   for (genvar k = 0; k < NODES; k++) begin : g_leaf
      if (k < NUM_CLIENTS) begin : g_used
         assign max_node[NODES-1+k] = tickets_ff[k];
         assign held[k]             = |tickets_ff[k];
      end else begin : g_pad
         assign max_node[NODES-1+k] = '0;
      end
   end

   for (genvar n = 0; n < NODES-1; n++) begin : g_node
      assign max_node[n] = (max_node[2*n+2] > max_node[2*n+1]) ?
                           max_node[2*n+2] : max_node[2*n+1];
   end

   assign largest   = max_node[0];
   assign client_ok = 32'(client) < NUM_CLIENTS;
   assign idx       = CLIENT_BITS'(client);

   always_comb begin
      update.status = STATUS_OK;
      update.issued = '0;
      wr_en         = 1'b0;
      wr_value      = '0;
      if (client_ok) begin
         case (op)
            OP_ACQUIRE: begin
               if (held[idx]) begin
                  update.status = STATUS_DUPLICATE;
               end else if (largest == {TICKET_BITS{1'b1}}) begin
                  update.status = STATUS_OVERFLOW;
               end else begin
                  wr_en         = 1'b1;
                  wr_value      = largest + 1'b1;
                  update.issued = ISSUED_BITS'(wr_value);
               end
            end
            OP_RELEASE: begin
               if (!held[idx]) begin
                  update.status = STATUS_NO_TICKET;
               end else begin
                  wr_en = 1'b1;
               end
            end
            default: begin
               update.status = STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_CLIENTS; k++) begin
            tickets_ff[k] <= '0;
         end
      end else if (apply && wr_en) begin
         tickets_ff[idx] <= wr_value;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> held == '0)
      else $error("Ticket table not empty after reset.");

   a_idle_stable: assert property (@(posedge clock) disable iff (reset)
      !apply |=> held == $past(held))
      else $error("Ticket table changed without an applied beat.");

   a_acquire_held: assert property (@(posedge clock) disable iff (reset)
      apply && op == OP_ACQUIRE && client_ok && update.status == STATUS_OK
      |=> tickets_ff[$past(idx)] == $past(largest) + 1'b1)
      else $error("Acquire did not store the next ticket.");

   a_refuse_keeps: assert property (@(posedge clock) disable iff (reset)
      apply && update.status != STATUS_OK |=> held == $past(held))
      else $error("Refused beat changed the ticket table.");

endmodule

// File: rtl/bta_grant_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bakery grant selection
// Comparator tree that finds the client with the smallest nonzero ticket,
// the lower client number winning ties.
// ----------------------------------------------------------------------------
module bta_grant_select #(
   parameter int NUM_CLIENTS = 16,
   parameter int TICKET_BITS = 16
) (
   input  logic [TICKET_BITS-1:0] tickets [NUM_CLIENTS],
   output bta_pkg::grant_type     grant
);
   import bta_pkg::*;

   localparam int CLIENT_BITS = $clog2(NUM_CLIENTS);
   localparam int NODES       = 1 << CLIENT_BITS;

   logic                   node_valid  [2*NODES-1];
   logic [TICKET_BITS-1:0] node_ticket [2*NODES-1];
   logic [CLIENT_BITS-1:0] node_idx    [2*NODES-1];

   for (genvar k = 0; k < NODES; k++) begin : g_leaf
      if (k < NUM_CLIENTS) begin : g_used
         assign node_valid[NODES-1+k]  = |tickets[k];
         assign node_ticket[NODES-1+k] = tickets[k];
      end else begin : g_pad
         assign node_valid[NODES-1+k]  = 1'b0;
         assign node_ticket[NODES-1+k] = '0;
      end
      assign node_idx[NODES-1+k] = CLIENT_BITS'(k);
   end

   for (genvar n = 0; n < NODES-1; n++) begin : g_node
      logic take_left;
      assign take_left = node_valid[2*n+1] &&
                         (!node_valid[2*n+2] || node_ticket[2*n+1] <= node_ticket[2*n+2]);
      assign node_valid[n]  = node_valid[2*n+1] || node_valid[2*n+2];
      assign node_ticket[n] = take_left ? node_ticket[2*n+1] : node_ticket[2*n+2];
      assign node_idx[n]    = take_left ? node_idx[2*n+1] : node_idx[2*n+2];
   end

   assign grant.valid  = node_valid[0];
   assign grant.client = node_valid[0] ? GRANT_CLIENT_BITS'(node_idx[0]) : '0;

endmodule
